// File: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int REQ_W  = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_QUERY      = 3'd4
    } t_req_type;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [DATA_W-1:0] push_data;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [OCC_W-1:0]  entry_count;
        logic              is_empty;
        logic [DATA_W-1:0] front_word;
        logic [DATA_W-1:0] back_word;
    } t_res;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic upd;
        logic rd;
    } t_cmd;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

endpackage

// File: rtl/core/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    output deq_pkg::t_cmd o_cmd
);
    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_RD,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;
    logic   accept;

    assign accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE, S_OUT: begin
                    r_done <= 1'b0;
                    if (accept) begin
                        r_state <= S_UPD;
                        r_busy  <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_UPD: begin
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_OUT;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b0;
                end
            endcase
        end
    end

    assign busy       = r_busy;
    assign o_done     = r_done;
    assign o_cmd.load = accept;
    assign o_cmd.upd  = (r_state == S_UPD);
    assign o_cmd.rd   = (r_state == S_RD);

endmodule

// File: rtl/core/deq_dp.sv
`timescale 1ns / 1ps

module deq_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  deq_pkg::t_cmd i_cmd,
    input  deq_pkg::t_req i_req,
    output deq_pkg::t_res o_res
);
    import deq_pkg::*;

    t_req              r_req;
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic [OCC_W-1:0]  r_occ;
    logic              r_ok;

    logic [IDX_W-1:0]  n_head;
    logic [IDX_W-1:0]  n_tail;
    logic [OCC_W-1:0]  n_occ;
    logic              n_ok;

    logic              full;
    logic              empty;
    logic              wr;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;

    assign full  = (r_occ == OCC_W'(DEPTH));
    assign empty = (r_occ == '0);

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        n_ok   = 1'b1;
        wr     = 1'b0;
        waddr  = r_tail;
        case (t_req_type'(r_req.req_type))
            REQ_PUSH_FRONT: begin
                if (full) begin
                    n_ok = 1'b0;
                end else begin
                    n_head = idx_dec(r_head);
                    waddr  = n_head;
                    wr     = 1'b1;
                    n_occ  = r_occ + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (full) begin
                    n_ok = 1'b0;
                end else begin
                    n_tail = idx_inc(r_tail);
                    wr     = 1'b1;
                    n_occ  = r_occ + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    n_ok = 1'b0;
                end else begin
                    n_head = idx_inc(r_head);
                    n_occ  = r_occ - 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (empty) begin
                    n_ok = 1'b0;
                end else begin
                    n_tail = idx_dec(r_tail);
                    n_occ  = r_occ - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else if (i_cmd.upd) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.upd) begin
            r_ok <= n_ok;
        end
    end

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.upd && wr),
        .i_waddr   (waddr),
        .i_wdata   (r_req.push_data),
        .i_re      (i_cmd.rd),
        .i_raddr_a (r_head),
        .i_raddr_b (idx_dec(r_tail)),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign o_res.ok          = r_ok;
    assign o_res.entry_count = r_occ;
    assign o_res.is_empty    = empty;
    assign o_res.front_word  = empty ? '0 : rdata_a;
    assign o_res.back_word   = empty ? '0 : rdata_b;

endmodule

// File: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH words in a ring buffer.
// Request: drive i_req and raise start; the beat is taken on a rising
// edge with start high and busy low. req_type selects push front, push
// back, pop front, pop back or query; other codes act as a query.
// A push when full or a pop when empty is refused (ok = 0), state kept.
// Result: o_res is valid for the single cycle o_done is high, carrying
// ok, entry count, empty flag and the front/back words (zero if empty).
// Steps: pointer update and slot write (S_UPD), registered RAM read
// (S_RD), result (S_OUT, o_done high). busy drops for the result
// cycle, so a new request can be taken while o_done is high, but not
// before the write-then-registered-read pass through the slot RAM ends.
// The receiver cannot stall; each result beat is taken as it appears.
// Reset (synchronous, active low) empties the queue and clears busy and
// o_done; slot contents are not cleared and need no clearing pass.

module double_ended_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  deq_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output deq_pkg::t_res o_res
);
    import deq_pkg::*;

    t_cmd cmd;

    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    deq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule

// File: rtl/core/deq_checker.sv
`timescale 1ns / 1ps

module deq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input deq_pkg::t_req i_req,
    input logic          busy,
    input logic          o_done,
    input deq_pkg::t_res o_res
);
    import deq_pkg::*;

    logic query_beat;

    // query and spare codes never get refused
    assign query_beat = start && !busy && (i_req.req_type >= REQ_QUERY);

    a_accept_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("result beat missing three cycles after request");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy high during result beat");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.is_empty == (o_res.entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.is_empty) |-> (o_res.front_word == '0 && o_res.back_word == '0))
        else $error("nonzero words reported on empty queue");

    a_query_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_beat |-> ##3 (o_done && o_res.ok))
        else $error("query beat reported as refused");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
